// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define OLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants, codes and controller/datapath signal groups of the
// ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // latch the accepted command
    logic compare;    // register the match vector
    logic exec;       // apply the command and load its single result
    logic dump_step;  // emit the front entry and rotate the list
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  in_op;      // command on the request channel
    logic out_free;   // result register can take a beat this cycle
    logic empty;      // no entries held
    logic dump_last;  // current dump beat is the final entry
  } sts_t;

endpackage

// ===== hdl/ole_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_req_if / ole_rsp_if
// Valid/ready channels carrying commands into and results out of the engine.
// ----------------------------------------------------------------------------
interface ole_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [ole_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface ole_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [ole_pkg::VALUE_W-1:0] entry;
  logic [ole_pkg::CNT_W-1:0]   count;
  logic                        last;

  modport source (output valid, output status, output entry, output count,
                  output last, input ready);
  modport sink (input valid, input status, input entry, input count,
                input last, output ready);
endinterface

// ===== hdl/ole_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ole_dp
// Datapath: row of list cells with parallel compare and shift, entry count,
// dump rotation and the result register.
// ----------------------------------------------------------------------------
module ole_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  ole_pkg::ctl_t               ctl,
  output ole_pkg::sts_t               sts,
  input  logic [1:0]                  in_cmd,
  input  logic [ole_pkg::VALUE_W-1:0] in_value,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic [2:0]                  rsp_status,
  output logic [ole_pkg::VALUE_W-1:0] rsp_entry,
  output logic [ole_pkg::CNT_W-1:0]   rsp_count,
  output logic                        rsp_last
);

  logic [ole_pkg::VALUE_W-1:0] cells [ole_pkg::DEPTH];
  logic [ole_pkg::VALUE_W-1:0] cells_next [ole_pkg::DEPTH];
  logic [ole_pkg::VALUE_W-1:0] cells_up [ole_pkg::DEPTH];
  logic [ole_pkg::VALUE_W-1:0] cells_dn [ole_pkg::DEPTH];
  logic [ole_pkg::CNT_W-1:0]   count;
  logic [ole_pkg::CNT_W-1:0]   count_next;
  logic [ole_pkg::IDX_W-1:0]   dump_idx;
  ole_pkg::op_t                op;
  logic [ole_pkg::VALUE_W-1:0] op_value;
  logic [ole_pkg::DEPTH-1:0]   match_q;
  logic [ole_pkg::DEPTH-1:0]   first;
  logic [ole_pkg::DEPTH-1:0]   after;
  logic                        found;
  logic                        full;
  logic                        load;
  ole_pkg::status_t            res_status;
  logic [ole_pkg::VALUE_W-1:0] res_entry;
  logic                        res_last;

  assign full  = (count == ole_pkg::CNT_W'(ole_pkg::DEPTH));
  assign found = |match_q;
  // One-hot of the frontmost match, then every cell at or behind it.
  assign first = match_q & (~match_q + 1'b1);
  assign after = ~(first - 1'b1);
  assign load  = ctl.exec | ctl.dump_step;

  assign sts.in_op     = ole_pkg::op_t'(in_cmd);
  assign sts.out_free  = ~rsp_valid | rsp_ready;
  assign sts.empty     = (count == '0);
  assign sts.dump_last = ({1'b0, dump_idx} == count - 1'b1);

  // Neighbor views of the row: one place toward the front, one toward the back.
  always_comb begin
    for (int i = 0; i < ole_pkg::DEPTH - 1; i++) begin
      cells_up[i] = cells[i + 1];
    end
    cells_up[ole_pkg::DEPTH-1] = cells[ole_pkg::DEPTH-1];
    cells_dn[0] = op_value;
    for (int i = 1; i < ole_pkg::DEPTH; i++) begin
      cells_dn[i] = cells[i - 1];
    end
  end

  always_comb begin
    cells_next = cells;
    count_next = count;
    res_status = ole_pkg::ST_DONE;
    res_entry  = '0;
    res_last   = 1'b1;
    if (ctl.exec) begin
      case (op)
        ole_pkg::OP_INSERT: begin
          if (full) begin
            res_status = ole_pkg::ST_FULL;
          end else begin
            cells_next = cells_dn;
            count_next = count + 1'b1;
          end
        end
        ole_pkg::OP_APPEND: begin
          if (full) begin
            res_status = ole_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < ole_pkg::DEPTH; i++) begin
              if (ole_pkg::CNT_W'(i) == count) cells_next[i] = op_value;
            end
            count_next = count + 1'b1;
          end
        end
        ole_pkg::OP_REMOVE: begin
          if (!found) begin
            res_status = ole_pkg::ST_NOTFOUND;
          end else begin
            // Close the gap behind the removed entry.
            for (int i = 0; i < ole_pkg::DEPTH; i++) begin
              if (after[i]) cells_next[i] = cells_up[i];
            end
            count_next = count - 1'b1;
          end
        end
        ole_pkg::OP_DUMP: begin
          res_status = ole_pkg::ST_EMPTY;
        end
        default: begin
          res_status = ole_pkg::ST_DONE;
        end
      endcase
    end else if (ctl.dump_step) begin
      // Emit the front and rotate it to the back of the held entries.
      res_status = ole_pkg::ST_ENTRY;
      res_entry  = cells[0];
      res_last   = sts.dump_last;
      for (int i = 0; i < ole_pkg::DEPTH; i++) begin
        if (ole_pkg::CNT_W'(i) + 1'b1 < count) begin
          cells_next[i] = cells_up[i];
        end else if (ole_pkg::CNT_W'(i) + 1'b1 == count) begin
          cells_next[i] = cells[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (ctl.capture) begin
      op       <= ole_pkg::op_t'(in_cmd);
      op_value <= in_value;
    end
    if (ctl.compare) begin
      for (int i = 0; i < ole_pkg::DEPTH; i++) begin
        match_q[i] <= (cells[i] == op_value) && (ole_pkg::CNT_W'(i) < count);
      end
    end
    if (load) begin
      rsp_status <= res_status;
      rsp_entry  <= res_entry;
      rsp_count  <= count_next;
      rsp_last   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctl.capture) begin
        dump_idx <= '0;
      end else if (ctl.dump_step) begin
        dump_idx <= dump_idx + 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `OLE_ASSERT(a_count_bound, count <= ole_pkg::CNT_W'(ole_pkg::DEPTH), "count beyond depth")
  `OLE_ASSERT(a_load_free, load |-> sts.out_free, "result loaded over a pending beat")
  `OLE_ASSERT(a_count_step, ctl.dump_step |=> $stable(count), "dump changed the count")

endmodule

// ===== hdl/ole_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ole_ctrl
// Controller: sequences capture, compare, execute and dump beats.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ole_pkg::sts_t sts,
  output ole_pkg::ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_EXEC,
    S_DUMP
  } state_t;

  state_t state;
  logic   accept;

  assign accept = req_valid & req_ready;

  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE:    ctl.capture = accept;
      S_COMPARE: ctl.compare = 1'b1;
      S_EXEC:    ctl.exec = sts.out_free;
      S_DUMP: begin
        ctl.exec      = sts.out_free & sts.empty;
        ctl.dump_step = sts.out_free & ~sts.empty;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_ready <= 1'b0;
            case (sts.in_op)
              ole_pkg::OP_REMOVE: state <= S_COMPARE;
              ole_pkg::OP_DUMP:   state <= S_DUMP;
              default:            state <= S_EXEC;
            endcase
          end
        end
        S_COMPARE: state <= S_EXEC;
        S_EXEC: begin
          if (sts.out_free) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        S_DUMP: begin
          if (sts.out_free && (sts.empty || sts.dump_last)) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

  `OLE_ASSERT(a_accept_busy, accept |=> !req_ready, "took a second command while busy")
  `OLE_ASSERT_ALWAYS(a_one_cmd, $onehot0(ctl), "more than one datapath command")
  `OLE_ASSERT(a_ready_idle, req_ready |-> state == S_IDLE, "ready outside idle")

endmodule

// ===== hdl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values with insert, append, remove
// and dump commands.
// ----------------------------------------------------------------------------
// Each command beat gives one result beat with last set, except a dump of a
// non-empty list, which streams every held entry front first and sets last on
// the final one. The list lives in a row of cells that compare and shift in
// parallel. Insert and append go from capture straight to execute; remove
// passes through a compare state that first registers the parallel compare.
// A dump rotates the row past its front cell, one entry per cycle while the
// result channel takes each beat. Results sit in an output register; a
// stalled result channel holds the engine at its next result beat.
module ordered_list_engine (
  input logic      clk,
  input logic      rst,
  ole_req_if.sink  req,
  ole_rsp_if.source rsp
);

  ole_pkg::ctl_t ctl;
  ole_pkg::sts_t sts;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ole_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (req.cmd),
    .in_value   (req.value),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_status (rsp.status),
    .rsp_entry  (rsp.entry),
    .rsp_count  (rsp.count),
    .rsp_last   (rsp.last)
  );

endmodule
